FILE: rtl/stsc_pkg.sv
package stsc_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD0,
        ST_REPLAY,
        ST_DECIDE,
        ST_EMIT
    } stsc_state_t;

    // one result item
    typedef struct packed {
        logic               last;
        logic signed [15:0] add;
        logic [15:0]        count;
        logic [31:0]        interval;
    } stsc_seg_t;

endpackage

FILE: rtl/stsc_div.sv
// restoring divider, one quotient bit per cycle, rounds half away from zero
module stsc_div
    import stsc_pkg::*;
#(
    parameter int NW = 44,
    parameter int DW = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic signed [15:0]   quo
);
    localparam int CW = $clog2(NW + 2);
    localparam int QW = NW + 1;

    logic [QW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [QW-1:0]   dd_reg, dd_next;
    logic [DW:0]     den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [QW-1:0]   mag;
    logic [QW-1:0]   shifted;
    logic [QW-1:0]   dext;

    // magnitude of the dividend, and the doubled divisor widened
    assign mag  = num[NW-1] ? QW'(-num) : QW'(num);
    assign dext = QW'(den_reg);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dd_next   = dd_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[QW-2:0], dd_reg[QW-1]};
        if (start) begin
            // (2|n| + d) / (2d)
            dd_next   = (mag << 1) + QW'(den);
            den_next  = {den, 1'b0};
            neg_next  = num[NW-1];
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dd_next = dd_reg << 1;
            if (shifted >= dext) begin
                rem_next = shifted - dext;
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dd_reg  <= dd_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    // saturate signed result to 16 bits
    always_comb begin
        if (neg_reg) begin
            quo = (quo_reg > QW'(32768)) ? 16'sh8000 : 16'(-quo_reg);
        end else begin
            quo = (quo_reg > QW'(32767)) ? 16'sh7fff : 16'(quo_reg);
        end
    end
    assign done = done_reg;
endmodule

FILE: rtl/stsc_store.sv
// step time memory, one write and one registered read port
module stsc_store
    import stsc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [39:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [39:0]   rdata
);
    logic [39:0] mem [DEPTH];
    logic [39:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
    assign rdata = rdata_reg;
endmodule

FILE: rtl/step_time_segment_compressor_core.sv
// a step opening a segment or finding it full skips to decide; else the divider
// runs, a read setup state follows, the held steps and the new step are replayed
// (ending early on a misfit), then the decide state; a last step adds the emit state
// throughput: one step at a time; a step is taken only when idle with no result held
// aresetn clears all control state; max_error resets to 256; the step memory is
// not cleared, only entries of the open segment are compared
module step_time_segment_compressor_core
    import stsc_pkg::*;
#(
    parameter int MAX_SEG_STEPS = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // step_time
    input  logic        s_tlast,    // is_last_step
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // seg_interval, seg_count, seg_add
    output logic        m_tlast     // is_last_segment
);
    localparam int AW = (MAX_SEG_STEPS > 2) ? $clog2(MAX_SEG_STEPS) : 1;
    localparam int LW = $clog2(MAX_SEG_STEPS + 1);
    localparam int NW = 44;
    localparam int DW = LW + FRAC_BITS;
    localparam logic [41:0] ONE = 42'(1) << FRAC_BITS;

    stsc_state_t state_reg, state_next;
    logic [23:0]            err_reg;
    logic [LW-1:0]          len_reg, len_next;
    logic [39:0]            base_reg, base_next;
    logic [39:0]            prev_reg, prev_next;
    logic [39:0]            first_reg, first_next;   // segment_times[0]
    logic [31:0]            fiw_reg, fiw_next;
    logic signed [15:0]     add_reg, add_next;
    logic [39:0]            t_reg, t_next;
    logic                   lst_reg, lst_next;
    logic signed [15:0]     tadd_reg, tadd_next;
    logic [LW-1:0]          k_reg, k_next;
    logic signed [33:0]     pi_reg, pi_next;
    logic signed [42:0]     pt_reg, pt_next;
    logic                   fit_reg, fit_next;
    stsc_seg_t              out_reg, out_next;
    logic                   ov_reg, ov_next;
    stsc_seg_t              pend_reg, pend_next;
    logic                   pv_reg, pv_next;

    logic                   div_start, div_done;
    logic signed [NW-1:0]   div_num;
    logic signed [15:0]     div_quo;
    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [39:0]            wdata, rdata;

    logic signed [42:0]     dt;
    logic [31:0]            mk_int;
    logic signed [33:0]     pic;
    logic signed [42:0]     pt_new, err_s;
    logic [42:0]            err_abs;
    logic [39:0]            actual;
    logic                   accept;

    // divider for add
    stsc_div #(.NW(NW), .DW(DW)) u_div (
        .aclk, .aresetn, .start(div_start), .num(div_num),
        .den(DW'(len_reg) << FRAC_BITS), .done(div_done), .quo(div_quo)
    );

    stsc_store #(.DEPTH(MAX_SEG_STEPS), .AW(AW)) u_store (
        .aclk, .we, .waddr, .wdata, .raddr, .rdata
    );

    // interval of a new segment: round((t - prev) / 2^FRAC_BITS), clamp 1..2^32-1
    always_comb begin
        logic signed [42:0] r;
        logic [42:0]        m;
        dt = 43'($signed({3'b0, t_reg})) - 43'($signed({3'b0, prev_reg}));
        m  = dt[42] ? 43'(-dt) : dt;
        m  = (m + 43'(ONE >> 1)) >> FRAC_BITS;
        r  = dt[42] ? 43'(-m) : 43'(m);
        if (r < 43'sd1) begin
            mk_int = 32'd1;
        end else if (r > 43'sd4294967295) begin
            mk_int = 32'hffffffff;
        end else begin
            mk_int = r[31:0];
        end
    end

    // replay step: clamp predicted interval, advance predicted time
    assign pic     = (pi_reg < 34'sd1) ? 34'sd1 : pi_reg;
    assign pt_new  = pt_reg + (43'(pic) <<< FRAC_BITS);
    assign actual  = (k_reg - 1'b1 == len_reg) ? t_reg : rdata;
    assign err_s   = pt_new - 43'($signed({3'b0, actual}));
    assign err_abs = err_s[42] ? 43'(-err_s) : 43'(err_s);

    // dividend from the incoming request; divider starts on accept if 0 < len < MAX
    assign div_num = 44'($signed({4'b0, s_tdata})) - 44'($signed({4'b0, prev_reg}))
                   - 44'($signed({4'b0, first_reg})) + 44'($signed({4'b0, base_reg}));
    assign s_tready = (state_reg == ST_IDLE) && !pv_reg && !ov_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;   base_next = base_reg;  prev_next = prev_reg;
        first_next = first_reg; fiw_next  = fiw_reg;   add_next  = add_reg;
        t_next     = t_reg;     lst_next  = lst_reg;   tadd_next = tadd_reg;
        k_next     = k_reg;     pi_next   = pi_reg;    pt_next   = pt_reg;
        fit_next   = fit_reg;
        out_next   = out_reg;   ov_next   = ov_reg;
        pend_next  = pend_reg;  pv_next   = pv_reg;
        div_start  = 1'b0;
        we         = 1'b0;
        waddr      = AW'(len_reg);
        wdata      = t_reg;
        raddr      = AW'(k_reg);

        // output register, pending second result behind it
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        if (pv_reg && (!ov_reg || m_tready)) begin
            out_next = pend_reg;
            ov_next  = 1'b1;
            pv_next  = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    t_next   = s_tdata;
                    lst_next = s_tlast;
                    fit_next = 1'b0;
                    if (len_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else if (len_reg < LW'(MAX_SEG_STEPS)) begin
                        state_next = ST_DIV;
                        div_start  = 1'b1;
                    end else begin
                        state_next = ST_DECIDE;
                        fit_next   = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                // divider started with the captured step
                if (div_done) begin
                    tadd_next  = div_quo;
                    state_next = ST_RD0;
                    k_next     = '0;
                end
            end
            ST_RD0: begin
                pi_next    = 34'(fiw_reg);
                pt_next    = 43'(base_reg);
                fit_next   = 1'b1;
                k_next     = LW'(1);
                state_next = ST_REPLAY;
                raddr      = '0;
            end
            ST_REPLAY: begin
                // k_reg-1 is the entry whose read data is here; compare it
                k_next  = k_reg + 1'b1;
                raddr   = AW'(k_reg);
                pt_next = pt_new;
                pi_next = pi_reg + 34'(tadd_reg);
                if (err_abs > 43'(err_reg)) begin
                    fit_next   = 1'b0;
                    state_next = ST_DECIDE;
                end else if (k_reg - 1'b1 == len_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                if (len_reg == '0) begin
                    base_next  = prev_reg;
                    first_next = t_reg;
                    fiw_next   = mk_int;
                    add_next   = '0;
                    len_next   = LW'(1);
                    we = 1'b1; waddr = '0;
                end else if (fit_reg) begin
                    we       = 1'b1;
                    len_next = len_reg + 1'b1;
                    add_next = tadd_reg;
                end else begin
                    out_next = '{last: 1'b0, add: add_reg,
                                 count: 16'(len_reg), interval: fiw_reg};
                    ov_next  = 1'b1;
                    base_next  = prev_reg;
                    first_next = t_reg;
                    fiw_next   = mk_int;
                    add_next   = '0;
                    len_next   = LW'(1);
                    we = 1'b1; waddr = '0;
                end
                prev_next = t_reg;
                if (lst_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                pend_next = '{last: 1'b1, add: add_reg,
                              count: 16'(len_reg), interval: fiw_reg};
                pv_next   = 1'b1;
                len_next  = '0; base_next = '0; prev_next = '0;
                fiw_next  = '0; add_next  = '0; first_next = '0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            err_reg   <= 24'd256;
            len_reg   <= '0; base_reg <= '0; prev_reg <= '0; first_reg <= '0;
            fiw_reg   <= '0; add_reg  <= '0;
            ov_reg    <= 1'b0; pv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                err_reg <= cfg_wdata;
            end
            len_reg <= len_next; base_reg <= base_next; prev_reg <= prev_next;
            first_reg <= first_next; fiw_reg <= fiw_next; add_reg <= add_next;
            ov_reg  <= ov_next; pv_reg <= pv_next;
        end
        t_reg <= t_next; lst_reg <= lst_next; tadd_reg <= tadd_next;
        k_reg <= k_next; pi_reg <= pi_next; pt_reg <= pt_next; fit_reg <= fit_next;
        out_reg <= out_next; pend_reg <= pend_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {out_reg.add, out_reg.count, out_reg.interval};
    assign m_tlast  = out_reg.last;

    // a held result is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost");
    // segment count never exceeds the maximum
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_SEG_STEPS))
        else $error("segment overflow");
    // no step taken while a result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> !s_tready)
        else $error("ready with pending result");
endmodule

FILE: bench/step_time_segment_compressor_core_test.sv
`timescale 1ns / 100ps

module step_time_segment_compressor_core_test;
    import stsc_pkg::*;

    localparam int MAX_SEG_STEPS = 1024;
    localparam int FRAC_BITS = 8;
    localparam int MAX_WAIT  = 16;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [23:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // step_time
    logic        s_tlast;   // is_last_step
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // seg_interval, seg_count, seg_add
    logic        m_tlast;   // is_last_segment

    step_time_segment_compressor_core #(
        .MAX_SEG_STEPS(MAX_SEG_STEPS),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic [23:0]        tol;
    logic [39:0]        held_times [MAX_SEG_STEPS];
    int unsigned        held_len;
    logic [39:0]        seg_origin;
    logic [39:0]        prev_time;
    logic [31:0]        first_ivl;
    logic signed [15:0] cur_add;

    stsc_seg_t expected_segs [$];
    int        n_errors;
    bit        hold_off;
    int        hold_cycles;
    bit        rand_stall;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    // rounded division, half away from zero
    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            return (num < 0) ? -q : q;
        end
    endfunction

    function automatic logic [31:0] whole_interval(longint diff);
        longint r;
        begin
            r = div_round(diff, longint'(1) << FRAC_BITS);
            if (r < 1) r = 1;
            if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
            return r[31:0];
        end
    endfunction

    task automatic push_seg(logic last);
        stsc_seg_t s;
        begin
            s.interval = first_ivl;
            s.count    = held_len[15:0];
            s.add      = cur_add;
            s.last     = last;
            expected_segs = {expected_segs, s};
        end
    endtask

    task automatic start_segment(logic [39:0] t);
        begin
            seg_origin    = prev_time;
            held_times[0] = t;
            held_len      = 1;
            first_ivl     = whole_interval(longint'(t) - longint'(seg_origin));
            cur_add       = '0;
        end
    endtask

    task automatic clear_segment();
        begin
            held_len   = 0;
            seg_origin = '0;
            prev_time  = '0;
            first_ivl  = '0;
            cur_add    = '0;
        end
    endtask

    // work out the segments that one step request gives
    task automatic compress_step(logic [39:0] t, logic last);
        bit          fits;
        int unsigned cnt;
        longint      first_raw, new_raw, a, pt, pi, act, err;
        begin
            if (held_len == 0) begin
                start_segment(t);
            end else begin
                fits = 1'b0;
                if (held_len < MAX_SEG_STEPS) begin
                    cnt = held_len + 1;
                    first_raw = longint'(held_times[0]) - longint'(seg_origin);
                    new_raw = longint'(t) - longint'(prev_time);
                    a = div_round(new_raw - first_raw, longint'(cnt - 1) << FRAC_BITS);
                    if (a > 32767) a = 32767;
                    if (a < -32768) a = -32768;
                    pt = longint'(seg_origin);
                    fits = 1'b1;
                    for (int k = 0; k < cnt; k++) begin
                        pi = longint'(first_ivl) + a * k;
                        act = (k < held_len) ? longint'(held_times[k]) : longint'(t);
                        if (pi < 1) pi = 1;
                        pt += pi << FRAC_BITS;
                        err = pt - act;
                        if (err < 0) err = -err;
                        if (err > longint'(tol)) begin
                            fits = 1'b0;
                            break;
                        end
                    end
                    if (fits) begin
                        held_times[held_len] = t;
                        held_len = cnt;
                        cur_add = a[15:0];
                    end
                end
                if (!fits) begin
                    push_seg(1'b0);
                    start_segment(t);
                end
            end
            prev_time = t;
            if (last) begin
                push_seg(1'b1);
                clear_segment();
            end
        end
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        stsc_seg_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_segs.size() == 0) begin
                    $error("unexpected segment %h last %b", m_tdata, m_tlast);
                    n_errors++;
                end else begin
                    e = expected_segs.pop_front();
                    if (m_tdata[31:0] !== e.interval) begin
                        $error("seg_interval exp %0d got %0d", e.interval, m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tdata[47:32] !== e.count) begin
                        $error("seg_count exp %0d got %0d", e.count, m_tdata[47:32]);
                        n_errors++;
                    end
                    if (m_tdata[63:48] !== e.add) begin
                        $error("seg_add exp %0d got %0d", e.add, $signed(m_tdata[63:48]));
                        n_errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("is_last_segment exp %b got %b", e.last, m_tlast);
                        n_errors++;
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if (rand_stall && $urandom_range(0, 2) == 0) begin
                    hold_cycles <= $urandom_range(1, MAX_WAIT);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // send one step request, with an optional gap before it; valid stays up
    // after acceptance until the next request or a drain takes it down
    task automatic send_step(logic [39:0] t, logic last, bit gap = 1'b1);
        int w;
        begin
            w = gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT)) : 0;
            if (w > 0) begin
                s_tvalid <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= t;
            s_tlast  <= last;
            compress_step(t, last);
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    task automatic wait_drained();
        begin
            s_tvalid <= 1'b0;
            while (expected_segs.size() != 0) @(posedge aclk);
            repeat (MAX_SEG_STEPS + 80) @(posedge aclk);
        end
    endtask

    task automatic write_tol(logic [23:0] v);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            tol = v;
            @(posedge aclk);
            cfg_we    <= 1'b0;
        end
    endtask

    // a run of n steps with random base, interval and acceleration, plus optional jitter
    task automatic send_run(int n, bit gap, longint jit);
        longint t, ivl, acc;
        begin
            t   = $urandom_range(0, 4000);
            ivl = $urandom_range(1, 3000) << FRAC_BITS;
            acc = $signed($urandom_range(0, 400)) - 200;
            for (int i = 0; i < n; i++) begin
                t += ivl + (jit ? ($signed($urandom_range(0, 2 * jit)) - jit) : 0);
                if (t < 0) t = 0;
                ivl += acc;
                if (ivl < 0) ivl = 64;
                send_step(t[39:0], i == n - 1, gap);
            end
        end
    endtask

    task automatic test_directed();
        begin
            send_step(40'd0, 1'b1);
            send_step(40'hFF_FFFF_FFFF, 1'b1);
            send_step(40'd1000, 1'b0);
            send_step(40'd500, 1'b0);
            send_step(40'd0, 1'b0);
            send_step(40'hFF_FFFF_FFFF, 1'b0);
            send_step(40'hFF_FFFF_FFFF, 1'b1);
            for (int i = 1; i <= 6; i++) send_step(40'd256 * i * 10, i == 6);
            send_step(40'd100_000, 1'b0);
            send_step(40'd100_256, 1'b0);
            send_step(40'd50_000_000, 1'b0);
            send_step(40'd50_000_000, 1'b0);
            send_step(40'd50_000_100, 1'b1);
            send_step(40'h55_5555_5555, 1'b0);
            send_step(40'hAA_AAAA_AAAA, 1'b1);
            wait_drained();
        end
    endtask

    task automatic test_random();
        logic [39:0] t;
        begin
            for (int r = 0; r < 26; r++) begin
                if (r == 13) rand_stall = 1'b0;
                if (r == 18) rand_stall = 1'b1;
                case ($urandom_range(0, 3))
                    0: send_run($urandom_range(2, 20), 1'b1, $urandom_range(0, 600));
                    1: send_run($urandom_range(2, 12), 1'b1, 0);
                    2: send_run($urandom_range(1, 6), 1'b0, 20000);
                    default: begin
                        for (int i = 0; i < 4; i++) begin
                            t = {$urandom(), 8'($urandom())};
                            send_step(t, ($urandom_range(0, 4) == 0) || i == 3);
                        end
                    end
                endcase
            end
            wait_drained();
        end
    endtask

    // receiver held off while steps keep coming in
    task automatic test_backpressure();
        begin
            hold_off = 1'b1;
            fork
                send_run(12, 1'b0, 5000);
                begin
                    repeat (3000) @(posedge aclk);
                    hold_off = 1'b0;
                end
            join
            wait_drained();
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        n_errors   = 0;
        hold_off   = 1'b0;
        hold_cycles = 0;
        rand_stall = 1'b1;
        tol        = 24'd256;
        clear_segment();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_tol(24'd0);
        test_directed();
        test_random();
        write_tol(24'hFF_FFFF);
        test_directed();
        test_random();
        write_tol(24'd1000);
        test_backpressure();
        write_tol(24'd64);
        test_random();

        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
